/* sv/separable_gaussian_blur_unit_defines.svh */
// ----------------------------------------------------------------------------
// separable gaussian blur unit defines
// assertion macros shared by the blur unit modules
// ----------------------------------------------------------------------------
`ifndef SEPARABLE_GAUSSIAN_BLUR_UNIT_DEFINES_SVH
`define SEPARABLE_GAUSSIAN_BLUR_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define SGB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, quiet during reset
`define SGB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/sgb_pkg.sv */
// ----------------------------------------------------------------------------
// sgb_pkg
// shared types, register indices and coefficient helpers of the blur unit
// ----------------------------------------------------------------------------
package sgb_pkg;

	localparam int WIDTH_BITS  = 11;
	localparam int HEIGHT_BITS = 16;
	localparam int RADIUS_BITS = 3;
	localparam int WORD_BITS   = 64;
	localparam int INDEX_BITS  = 3;
	localparam int CHAN_BITS   = 8;
	localparam int PIX_BITS    = 3 * CHAN_BITS;
	localparam int TAP_BITS    = 16;
	localparam int VERT_BITS   = 16;
	localparam logic [VERT_BITS-1:0] VERT_FULL = 16'd65280;
	localparam logic [CHAN_BITS-1:0] CHAN_FULL = 8'd255;

	// register indices
	localparam logic [INDEX_BITS-1:0] REG_WIDTH   = 3'd0;
	localparam logic [INDEX_BITS-1:0] REG_HEIGHT  = 3'd1;
	localparam logic [INDEX_BITS-1:0] REG_RADIUS  = 3'd2;
	localparam logic [INDEX_BITS-1:0] REG_COEF_LO = 3'd3;
	localparam logic [INDEX_BITS-1:0] REG_COEF_HI = 3'd4;

	// effective configuration (width, height and radius already clamped)
	typedef struct packed {
		logic [WIDTH_BITS-1:0]  width;
		logic [HEIGHT_BITS-1:0] height;
		logic [RADIUS_BITS-1:0] radius;
		logic [WORD_BITS-1:0]   coef_lo;
		logic [WORD_BITS-1:0]   coef_hi;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic                   wr_en;
		logic                   rd_en;
		logic                   first_v;
		logic                   last_v;
		logic                   first_h;
		logic                   last_h;
		logic [RADIUS_BITS-1:0] tap_v;
		logic [RADIUS_BITS-1:0] tap_h;
		logic                   frame_end;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hold_full;
		logic res_done;
	} sts_t;

	// 16-bit tap field, taps 0..3 in the low word, 4..7 in the high word
	function automatic logic [TAP_BITS-1:0] tap_field(
		input logic [WORD_BITS-1:0]   lo,
		input logic [WORD_BITS-1:0]   hi,
		input logic [RADIUS_BITS-1:0] idx
	);
		logic [WORD_BITS-1:0] word;
		word = idx[2] ? hi : lo;
		return word[idx[1:0]*TAP_BITS +: TAP_BITS];
	endfunction

endpackage

/* sv/sgb_ram.sv */
// ----------------------------------------------------------------------------
// sgb_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sgb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/sgb_ctrl.sv */
// ----------------------------------------------------------------------------
// sgb_ctrl
// frame position tracking and tap sequencer of the blur unit
// ----------------------------------------------------------------------------
`include "separable_gaussian_blur_unit_defines.svh"

module sgb_ctrl #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 7,
	localparam int RING  = 2 * MAX_RADIUS + 2,
	localparam int SLOTW = $clog2(RING),
	localparam int COLW  = $clog2(MAX_WIDTH),
	localparam int AW    = SLOTW + COLW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sgb_pkg::cfg_t cfg,
	input  logic          cfg_wr,
	input  logic          in_valid,
	input  logic          func,
	output logic          in_ready,
	input  sgb_pkg::sts_t sts,
	output sgb_pkg::cmd_t cmd,
	output logic [AW-1:0] wr_addr,
	output logic [AW-1:0] rd_addr
);

	localparam int DIFFW = COLW + sgb_pkg::HEIGHT_BITS + 1;
	localparam int WW    = sgb_pkg::HEIGHT_BITS + 2;
	localparam int SW    = SLOTW + 2;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0]                      state_q;
	logic [sgb_pkg::HEIGHT_BITS-1:0] in_row_q, out_row_q, job_row_q;
	logic [COLW-1:0]                 in_col_q, out_col_q, job_col_q;
	logic [SLOTW-1:0]                in_slot_q, out_slot_q, job_slot_q;
	logic                            in_done_q, job_fe_q;
	logic [DIFFW-1:0]                diff_q;
	logic signed [4:0]               dv_q, dh_q;

	logic             accept, new_in, in_wrap, in_row_last, fills, emit;
	logic             last_out, out_wrap, issue_last;
	logic [WW-1:0]    w18, h18;
	logic [DIFFW-1:0] diff_st, thresh;
	logic signed [4:0] r5, rneg;
	logic signed [WW-1:0] row_s, col_s, rsum, csum, rr, cc, roff, hm1, wm1;
	logic signed [SW-1:0] slot_raw, slot_fix;

	always_comb begin
		w18 = WW'(cfg.width);
		h18 = WW'(cfg.height);
		accept = in_valid && in_ready;
		new_in = accept && !func && !in_done_q;
		in_wrap = WW'(in_col_q) == w18 - WW'(1);
		in_row_last = WW'(in_row_q) == h18 - WW'(1);
		fills = new_in && in_wrap && in_row_last;
		diff_st = diff_q + DIFFW'(new_in);
		// an output is due once its lowest tap row and right tap column are in
		thresh = DIFFW'(cfg.radius) * DIFFW'(cfg.width) + DIFFW'(cfg.radius);
		emit = accept && (in_done_q || fills || diff_st > thresh);
		out_wrap = WW'(out_col_q) == w18 - WW'(1);
		last_out = out_wrap && (WW'(out_row_q) == h18 - WW'(1));
	end

	// tap address: clamp to the frame edges, then map the row into the ring
	always_comb begin
		r5 = $signed({2'b00, cfg.radius});
		rneg = 5'sd0 - r5;
		row_s = $signed(WW'(job_row_q));
		col_s = $signed(WW'(job_col_q));
		hm1 = $signed(h18 - WW'(1));
		wm1 = $signed(w18 - WW'(1));
		rsum = row_s + WW'(dv_q);
		csum = col_s + WW'(dh_q);
		if (rsum < 0) begin
			rr = '0;
		end else if (rsum > hm1) begin
			rr = hm1;
		end else begin
			rr = rsum;
		end
		if (csum < 0) begin
			cc = '0;
		end else if (csum > wm1) begin
			cc = wm1;
		end else begin
			cc = csum;
		end
		roff = rr - row_s;
		slot_raw = $signed(SW'(job_slot_q)) + SW'(roff);
		if (slot_raw < 0) begin
			slot_fix = slot_raw + SW'(RING);
		end else if (slot_raw >= SW'(RING)) begin
			slot_fix = slot_raw - SW'(RING);
		end else begin
			slot_fix = slot_raw;
		end
		rd_addr = {slot_fix[SLOTW-1:0], cc[COLW-1:0]};
		wr_addr = {in_slot_q, in_col_q};
		issue_last = (dv_q == r5) && (dh_q == r5);
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE) && !sts.hold_full;
		cmd.wr_en = new_in;
		cmd.rd_en = state_q == ST_RUN;
		cmd.first_v = dv_q == rneg;
		cmd.last_v = dv_q == r5;
		cmd.first_h = dh_q == rneg;
		cmd.last_h = dh_q == r5;
		cmd.tap_v = dv_q[4] ? 3'(-dv_q) : dv_q[2:0];
		cmd.tap_h = dh_q[4] ? 3'(-dh_q) : dh_q[2:0];
		cmd.frame_end = job_fe_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			in_row_q <= '0;
			in_col_q <= '0;
			in_slot_q <= '0;
			in_done_q <= 1'b0;
			diff_q <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			out_slot_q <= '0;
			dv_q <= '0;
			dh_q <= '0;
		end else begin
			if (cfg_wr || (emit && last_out)) begin
				in_row_q <= '0;
				in_col_q <= '0;
				in_slot_q <= '0;
				in_done_q <= 1'b0;
				diff_q <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
				out_slot_q <= '0;
			end else if (accept) begin
				if (new_in) begin
					if (in_wrap) begin
						in_col_q <= '0;
						in_row_q <= in_row_q + 1'b1;
						in_slot_q <= (in_slot_q == SLOTW'(RING - 1)) ? '0 : in_slot_q + 1'b1;
						if (in_row_last) begin
							in_done_q <= 1'b1;
						end
					end else begin
						in_col_q <= in_col_q + 1'b1;
					end
				end
				diff_q <= diff_st - DIFFW'(emit);
				if (emit) begin
					if (out_wrap) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + 1'b1;
						out_slot_q <= (out_slot_q == SLOTW'(RING - 1)) ? '0 : out_slot_q + 1'b1;
					end else begin
						out_col_q <= out_col_q + 1'b1;
					end
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (emit) begin
						state_q <= ST_RUN;
						dv_q <= rneg;
						dh_q <= rneg;
					end
				end
				ST_RUN: begin
					if (issue_last) begin
						state_q <= ST_WAIT;
					end
					if (dv_q == r5) begin
						dv_q <= rneg;
						dh_q <= dh_q + 5'sd1;
					end else begin
						dv_q <= dv_q + 5'sd1;
					end
				end
				ST_WAIT: begin
					if (sts.res_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// job snapshot for the sequencer
	always_ff @(posedge clk) begin
		if (emit) begin
			job_row_q <= out_row_q;
			job_col_q <= out_col_q;
			job_slot_q <= out_slot_q;
			job_fe_q <= last_out;
		end
	end

	`SGB_ASSERT_NOW(a_wr_on_accept, cmd.wr_en, in_valid && in_ready, "row store write without item")
	`SGB_ASSERT_NEXT(a_run_to_wait, (state_q == ST_RUN) && issue_last, state_q == ST_WAIT,
		"sequencer did not stop after last tap")
	`SGB_ASSERT_NOW(a_done_in_wait, sts.res_done, state_q == ST_WAIT, "result outside a job")

endmodule

/* sv/sgb_dpath.sv */
// ----------------------------------------------------------------------------
// sgb_dpath
// row store, vertical and horizontal multiply-accumulate, output staging
// ----------------------------------------------------------------------------
`include "separable_gaussian_blur_unit_defines.svh"

module sgb_dpath #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 7,
	parameter int COEF_BITS  = 16,
	localparam int RING  = 2 * MAX_RADIUS + 2,
	localparam int SLOTW = $clog2(RING),
	localparam int COLW  = $clog2(MAX_WIDTH),
	localparam int AW    = SLOTW + COLW
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sgb_pkg::cmd_t                       cmd,
	input  logic [AW-1:0]                       wr_addr,
	input  logic [AW-1:0]                       rd_addr,
	input  logic [sgb_pkg::PIX_BITS-1:0]        pixel,
	input  logic [sgb_pkg::WORD_BITS-1:0]       coef_lo,
	input  logic [sgb_pkg::WORD_BITS-1:0]       coef_hi,
	output sgb_pkg::sts_t                       sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sgb_pkg::CHAN_BITS-1:0]       red_out,
	output logic [sgb_pkg::CHAN_BITS-1:0]       green_out,
	output logic [sgb_pkg::CHAN_BITS-1:0]       blue_out,
	output logic                                frame_end
);

	localparam int CB    = COEF_BITS;
	localparam int PW    = CB + sgb_pkg::CHAN_BITS;
	localparam int VACCW = PW + 4;
	localparam int HPW   = CB + sgb_pkg::VERT_BITS;
	localparam int HACCW = HPW + 4;
	localparam int SH    = CB - 8;
	localparam logic [VACCW:0] VRND = (SH > 0) ? ((VACCW + 1)'(1) << (SH - 1)) : '0;
	localparam logic [HACCW:0] HRND = (HACCW + 1)'(1) << (CB + 7);

	logic [sgb_pkg::PIX_BITS-1:0] rdata;

	logic          v_s1, first_v_s1, last_v_s1, first_h_s1, last_h_s1;
	logic [CB-1:0] coef_v_s1, coef_h_s1;
	logic          v_s2, first_v_s2, last_v_s2, first_h_s2, last_h_s2;
	logic [CB-1:0] coef_h_s2;
	logic [PW-1:0] prod_s2 [3];
	logic [VACCW-1:0] vacc_q [3];
	logic          vdone_s3, first_h_s3, last_h_s3;
	logic [CB-1:0] coef_h_s3;
	logic          v_s4, first_h_s4, last_h_s4;
	logic [CB-1:0] coef_h_s4;
	logic [sgb_pkg::VERT_BITS-1:0] vert_s4 [3];
	logic          v_s5, first_h_s5, last_h_s5;
	logic [HPW-1:0] hprod_s5 [3];
	logic [HACCW-1:0] hacc_q [3];
	logic          hdone_s6;
	logic          hold_valid_q;
	logic          hold_fe_q;
	logic [sgb_pkg::CHAN_BITS-1:0] hold_q [3];
	logic [sgb_pkg::CHAN_BITS-1:0] out_q [3];

	logic [VACCW:0] vsum [3];
	logic [VACCW:0] vsh [3];
	logic [sgb_pkg::VERT_BITS-1:0] vsat [3];
	logic [HACCW:0] hsum [3];
	logic [HACCW:0] hsh [3];
	logic [sgb_pkg::CHAN_BITS-1:0] hsat [3];
	logic move;

	sgb_ram #(
		.WIDTH(sgb_pkg::PIX_BITS),
		.DEPTH(RING << COLW)
	) u_row_store (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(wr_addr),
		.wdata(pixel),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	// rounding and saturation of both passes
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vsum[i] = {1'b0, vacc_q[i]} + VRND;
			vsh[i] = vsum[i] >> SH;
			vsat[i] = (vsh[i] > (VACCW + 1)'(sgb_pkg::VERT_FULL)) ?
				sgb_pkg::VERT_FULL : vsh[i][sgb_pkg::VERT_BITS-1:0];
			hsum[i] = {1'b0, hacc_q[i]} + HRND;
			hsh[i] = hsum[i] >> (CB + 8);
			hsat[i] = (hsh[i] > (HACCW + 1)'(sgb_pkg::CHAN_FULL)) ?
				sgb_pkg::CHAN_FULL : hsh[i][sgb_pkg::CHAN_BITS-1:0];
		end
		move = hold_valid_q && (!out_valid || out_ready);
		sts.hold_full = hold_valid_q;
		sts.res_done = hdone_s6;
	end

	// stage flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			vdone_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			hdone_s6 <= 1'b0;
			hold_valid_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			vdone_s3 <= v_s2 && last_v_s2;
			v_s4 <= vdone_s3;
			v_s5 <= v_s4;
			hdone_s6 <= v_s5 && last_h_s5;
			if (hdone_s6) begin
				hold_valid_q <= 1'b1;
			end else if (move) begin
				hold_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		first_v_s1 <= cmd.first_v;
		last_v_s1 <= cmd.last_v;
		first_h_s1 <= cmd.first_h;
		last_h_s1 <= cmd.last_h;
		coef_v_s1 <= CB'(sgb_pkg::tap_field(coef_lo, coef_hi, cmd.tap_v));
		coef_h_s1 <= CB'(sgb_pkg::tap_field(coef_lo, coef_hi, cmd.tap_h));

		first_v_s2 <= first_v_s1;
		last_v_s2 <= last_v_s1;
		first_h_s2 <= first_h_s1;
		last_h_s2 <= last_h_s1;
		coef_h_s2 <= coef_h_s1;
		for (int i = 0; i < 3; i++) begin
			prod_s2[i] <= PW'(rdata[(2 - i) * sgb_pkg::CHAN_BITS +: sgb_pkg::CHAN_BITS])
				* PW'(coef_v_s1);
		end

		// column sum over the vertical taps
		if (v_s2) begin
			for (int i = 0; i < 3; i++) begin
				vacc_q[i] <= first_v_s2 ? VACCW'(prod_s2[i]) : vacc_q[i] + VACCW'(prod_s2[i]);
			end
		end
		first_h_s3 <= first_h_s2;
		last_h_s3 <= last_h_s2;
		coef_h_s3 <= coef_h_s2;

		for (int i = 0; i < 3; i++) begin
			vert_s4[i] <= vsat[i];
		end
		first_h_s4 <= first_h_s3;
		last_h_s4 <= last_h_s3;
		coef_h_s4 <= coef_h_s3;

		for (int i = 0; i < 3; i++) begin
			hprod_s5[i] <= HPW'(vert_s4[i]) * HPW'(coef_h_s4);
		end
		first_h_s5 <= first_h_s4;
		last_h_s5 <= last_h_s4;

		// row sum over the horizontal taps
		if (v_s5) begin
			for (int i = 0; i < 3; i++) begin
				hacc_q[i] <= first_h_s5 ? HACCW'(hprod_s5[i]) : hacc_q[i] + HACCW'(hprod_s5[i]);
			end
		end

		if (hdone_s6) begin
			for (int i = 0; i < 3; i++) begin
				hold_q[i] <= hsat[i];
			end
			hold_fe_q <= cmd.frame_end;
		end
		if (move) begin
			for (int i = 0; i < 3; i++) begin
				out_q[i] <= hold_q[i];
			end
			frame_end <= hold_fe_q;
		end
	end

	assign red_out = out_q[0];
	assign green_out = out_q[1];
	assign blue_out = out_q[2];

	`SGB_ASSERT_NOW(a_hold_free, hdone_s6, !hold_valid_q, "result overwrote a held result")

endmodule

/* sv/separable_gaussian_blur_unit.sv */
// an item without a result is taken without starting a job; an item with a result starts
//   a job that reads all its taps and hands the result on to the output register
// a new item is taken only after that result has left the hold register; the single read
//   port of the row store delivers one tap pixel per cycle while a job runs
// reset: position counters cleared, configuration registers to defaults, row store left as is
// ----------------------------------------------------------------------------
// separable_gaussian_blur_unit
// streaming rgb blur, vertical then horizontal pass with replicated edges
// ----------------------------------------------------------------------------
module separable_gaussian_blur_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 7,
	parameter int COEF_BITS  = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_wen,
	input  logic [sgb_pkg::INDEX_BITS-1:0]        cfg_index,
	input  logic [sgb_pkg::WORD_BITS-1:0]         cfg_data,
	// input item channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  func,
	input  logic [sgb_pkg::CHAN_BITS-1:0]         red_in,
	input  logic [sgb_pkg::CHAN_BITS-1:0]         green_in,
	input  logic [sgb_pkg::CHAN_BITS-1:0]         blue_in,
	// result item channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [sgb_pkg::CHAN_BITS-1:0]         red_out,
	output logic [sgb_pkg::CHAN_BITS-1:0]         green_out,
	output logic [sgb_pkg::CHAN_BITS-1:0]         blue_out,
	output logic                                  frame_end
);

	// ring of rows: enough for the full vertical window plus the row being filled
	localparam int RING  = 2 * MAX_RADIUS + 2;
	localparam int SLOTW = $clog2(RING);
	localparam int COLW  = $clog2(MAX_WIDTH);
	localparam int AW    = SLOTW + COLW;

	// raw configuration registers
	logic [sgb_pkg::WIDTH_BITS-1:0]  width_q;
	logic [sgb_pkg::HEIGHT_BITS-1:0] height_q;
	logic [sgb_pkg::RADIUS_BITS-1:0] radius_q;
	logic [sgb_pkg::WORD_BITS-1:0]   coef_lo_q;
	logic [sgb_pkg::WORD_BITS-1:0]   coef_hi_q;

	sgb_pkg::cfg_t cfg;
	sgb_pkg::cmd_t cmd;
	sgb_pkg::sts_t sts;
	logic          cfg_wr;
	logic [AW-1:0] wr_addr, rd_addr;

	// any write to a known register restarts the frame
	assign cfg_wr = cfg_wen && (cfg_index <= sgb_pkg::REG_COEF_HI);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'd1024;
			height_q <= 16'd1;
			radius_q <= 3'd0;
			coef_lo_q <= 64'd65535;
			coef_hi_q <= 64'd0;
		end else if (cfg_wen) begin
			case (cfg_index)
				sgb_pkg::REG_WIDTH:   width_q <= cfg_data[sgb_pkg::WIDTH_BITS-1:0];
				sgb_pkg::REG_HEIGHT:  height_q <= cfg_data[sgb_pkg::HEIGHT_BITS-1:0];
				sgb_pkg::REG_RADIUS:  radius_q <= cfg_data[sgb_pkg::RADIUS_BITS-1:0];
				sgb_pkg::REG_COEF_LO: coef_lo_q <= cfg_data;
				sgb_pkg::REG_COEF_HI: coef_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective values: zero width or height acts as one, oversize values clamp
	always_comb begin
		if (width_q == '0) begin
			cfg.width = sgb_pkg::WIDTH_BITS'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			cfg.width = sgb_pkg::WIDTH_BITS'(MAX_WIDTH);
		end else begin
			cfg.width = width_q;
		end
		cfg.height = (height_q == '0) ? sgb_pkg::HEIGHT_BITS'(1) : height_q;
		cfg.radius = (32'(radius_q) > MAX_RADIUS) ? sgb_pkg::RADIUS_BITS'(MAX_RADIUS) : radius_q;
		cfg.coef_lo = coef_lo_q;
		cfg.coef_hi = coef_hi_q;
	end

	// position tracking and tap sequencing
	sgb_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_RADIUS(MAX_RADIUS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_wr  (cfg_wr),
		.in_valid(in_valid),
		.func    (func),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr)
	);

	// row store, both filter passes and the output register
	sgb_dpath #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_RADIUS(MAX_RADIUS),
		.COEF_BITS (COEF_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr),
		.pixel    ({red_in, green_in, blue_in}),
		.coef_lo  (cfg.coef_lo),
		.coef_hi  (cfg.coef_hi),
		.sts      (sts),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red_out  (red_out),
		.green_out(green_out),
		.blue_out (blue_out),
		.frame_end(frame_end)
	);

endmodule
